// ===== design/gain_mute_solo_mixer_defines.svh =====
// Assertion macros for the gain/mute/solo mixer.
// Checks compile in simulation only; synthesis builds see empty bodies.
`ifndef GAIN_MUTE_SOLO_MIXER_DEFINES_SVH
`define GAIN_MUTE_SOLO_MIXER_DEFINES_SVH

`ifndef SYNTH

// A condition that must hold at every clock edge outside reset.
`define GMSM_ASSERT_NOW(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define GMSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GMSM_ASSERT_NOW(label, clk, rst_n, expr, msg)
`define GMSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/gmsm_pkg.sv =====
`timescale 1ns / 1ps

package gmsm_pkg;

  // Default channel count and depth of the queue between front and back.
  localparam int NUM_CHANNELS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Field widths of the item and result channels.
  localparam int CHAN_W    = 5;
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 18;
  localparam int MIX_W     = 24;
  localparam int PROD_W    = SAMPLE_W + GAIN_W;
  localparam int ACC_W     = 48;
  localparam int GAIN_FRAC = 14;
  localparam int SH_W      = ACC_W - GAIN_FRAC;

  // Wide enough to hold any channel index up to the largest channel count.
  localparam int CHAN_EXT_W = 9;

  localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 18'sd16384;
  localparam logic signed [ACC_W-1:0]  ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [MIX_W-1:0]  MIX_MAX    = {1'b0, {(MIX_W-1){1'b1}}};
  localparam logic signed [MIX_W-1:0]  MIX_MIN    = {1'b1, {(MIX_W-1){1'b0}}};

  // Item command codes.
  typedef enum logic {
    CMD_SETTINGS = 1'b0,
    CMD_SAMPLE   = 1'b1
  } cmd_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    cmd_t                       cmd;
    logic                       chan_ok;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [GAIN_W-1:0]   gain;
    logic                       mute;
    logic                       solo;
    logic                       last;
  } gmsm_item_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } back_state_t;

  // Back end status reported to the top level.
  typedef struct packed {
    back_state_t state;
    logic        emit;
    logic        acc_zero;
  } back_status_t;

endpackage

// ===== design/gain_mute_solo_mixer.sv =====
`timescale 1ns / 1ps
// Gain, mute and solo mixer for up to NUM_CHANNELS channels (channel field 0 to 31).
// Input items use in_valid/in_stall. in_cmd low writes gain, mute and solo for
// in_channel; in_cmd high carries one sample for in_channel, and in_last closes
// the frame. One result item (out_mix, out_clipped) leaves per closed frame on
// out_valid/out_stall: the Q1.23 sum of sample times gain over the contributing
// channels, floored and saturated, with out_clipped set when it saturated.
// A front end accepts items into a QUEUE_DEPTH entry queue; the back end runs
// them in order. A settings item is applied as it is popped, a contributing
// sample passes through queue pop with gain read, multiply and accumulate, a
// muted or silenced sample is only popped, and a closing sample then passes
// through an emit step that loads the output register. Sustained rate is set
// by the single multiply-accumulate sequencer.
// While out_stall is high the result holds, the back end runs on until its next
// emit step and waits there, and the front keeps filling the queue; in_stall
// rises only when it is full.
// Synchronous reset restores unity gain, clears mute, solo and the accumulator,
// and empties the queue; no clearing pass is needed.

`include "gain_mute_solo_mixer_defines.svh"

module gain_mute_solo_mixer #(
  parameter int NUM_CHANNELS = gmsm_pkg::NUM_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = gmsm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [gmsm_pkg::CHAN_W-1:0]           in_channel,
  input  logic signed [gmsm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic signed [gmsm_pkg::GAIN_W-1:0]    in_gain,
  input  logic                                  in_mute,
  input  logic                                  in_solo,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gmsm_pkg::MIX_W-1:0]     out_mix,
  output logic                                  out_clipped
);

  import gmsm_pkg::*;

  queue_status_t q_status;
  gmsm_item_t    q_item;
  gmsm_item_t    q_head;
  logic          q_push;
  logic          q_pop;
  back_status_t  bk_status;

  // Accept and classify items.
  gmsm_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .in_gain    (in_gain),
    .in_mute    (in_mute),
    .in_solo    (in_solo),
    .in_last    (in_last),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // Queue between the two halves.
  gmsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  // Settings store, multiply-accumulate and result register.
  gmsm_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_mix     (out_mix),
    .out_clipped (out_clipped),
    .status      (bk_status)
  );

  // Checks on the interplay of front, queue and back end.
  `GMSM_ASSERT_NOW(a_no_push_when_full, clk, rst_n, !(q_push && q_status.full), "push into full queue")
  `GMSM_ASSERT_NOW(a_pop_only_idle, clk, rst_n, !(q_pop && (bk_status.state != ST_IDLE)), "pop while busy")
  `GMSM_ASSERT_NEXT(a_emit_clears_acc, clk, rst_n, bk_status.emit, bk_status.acc_zero, "acc not cleared")
  `GMSM_ASSERT_NEXT(a_emit_shows_result, clk, rst_n, bk_status.emit, out_valid, "result lost")

endmodule

// ===== design/gmsm_ram.sv =====
`timescale 1ns / 1ps

module gmsm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/gmsm_front.sv =====
`timescale 1ns / 1ps

module gmsm_front #(
  parameter int NUM_CHANNELS = 32
) (
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [gmsm_pkg::CHAN_W-1:0]           in_channel,
  input  logic signed [gmsm_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic signed [gmsm_pkg::GAIN_W-1:0]    in_gain,
  input  logic                                  in_mute,
  input  logic                                  in_solo,
  input  logic                                  in_last,
  input  gmsm_pkg::queue_status_t               q_status,
  output logic                                  q_push,
  output gmsm_pkg::gmsm_item_t                  q_item
);

  import gmsm_pkg::*;

  logic accept;
  logic chan_ok;
  logic [CHAN_EXT_W-1:0] chan_ext;

  // Take an item whenever the queue has room.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // Channels beyond the configured count address nothing.
  assign chan_ext = CHAN_EXT_W'(in_channel);
  assign chan_ok  = chan_ext < CHAN_EXT_W'(NUM_CHANNELS);

  // Settings items for a missing channel are dropped here; samples always go on
  // because their last bit still closes the frame.
  assign q_push = accept && ((cmd_t'(in_cmd) == CMD_SAMPLE) || chan_ok);

  always_comb begin
    q_item.cmd     = cmd_t'(in_cmd);
    q_item.chan_ok = chan_ok;
    q_item.channel = in_channel;
    q_item.sample  = in_sample;
    q_item.gain    = in_gain;
    q_item.mute    = in_mute;
    q_item.solo    = in_solo;
    q_item.last    = in_last;
  end

endmodule

// ===== design/gmsm_queue.sv =====
`timescale 1ns / 1ps

module gmsm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  gmsm_pkg::gmsm_item_t    push_item,
  input  logic                    pop,
  output gmsm_pkg::gmsm_item_t    head,
  output gmsm_pkg::queue_status_t status
);

  import gmsm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gmsm_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  // Pointer and count updates, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Item storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/gmsm_back.sv =====
`timescale 1ns / 1ps

module gmsm_back #(
  parameter int NUM_CHANNELS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gmsm_pkg::gmsm_item_t               head,
  input  gmsm_pkg::queue_status_t            q_status,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gmsm_pkg::MIX_W-1:0]  out_mix,
  output logic                               out_clipped,
  output gmsm_pkg::back_status_t             status
);

  import gmsm_pkg::*;

  localparam int IDX_W = $clog2(NUM_CHANNELS);
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  back_state_t state_r, state_nxt;

  logic [NUM_CHANNELS-1:0] mute_r;
  logic [NUM_CHANNELS-1:0] solo_r;
  logic [NUM_CHANNELS-1:0] gvld_r;
  logic [CNT_W-1:0]        solo_cnt_r, solo_cnt_nxt;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;
  logic                       rd_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;

  logic                    out_valid_r;
  logic signed [MIX_W-1:0] out_mix_r, mix_nxt;
  logic                    out_clipped_r, clip_nxt;

  logic [CHAN_EXT_W-1:0]    chan_ext;
  logic [IDX_W-1:0]         idx;
  logic                     avail;
  logic                     contrib;
  logic                     out_free;
  logic                     set_we;
  logic                     rd_en;
  logic                     mul_en;
  logic                     acc_en;
  logic                     emit;
  logic [GAIN_W-1:0]        ram_rdata;
  logic signed [GAIN_W-1:0] gain_eff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W:0]    sum;
  logic [SH_W-1:0]          shifted;
  logic                     fits;

  // Decode of the item at the head of the queue.
  assign chan_ext = CHAN_EXT_W'(head.channel);
  assign idx      = chan_ext[IDX_W-1:0];
  assign avail    = !q_status.empty;
  assign contrib  = head.chan_ok && !mute_r[idx] && (solo_r[idx] || (solo_cnt_r == '0));
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (avail && (head.cmd == CMD_SAMPLE)) begin
          if (contrib) begin
            state_nxt = ST_MUL;
          end else if (head.last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop  = 1'b0;
    set_we = 1'b0;
    rd_en  = 1'b0;
    mul_en = 1'b0;
    acc_en = 1'b0;
    emit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop  = avail;
        set_we = avail && (head.cmd == CMD_SETTINGS) && head.chan_ok;
        rd_en  = avail && (head.cmd == CMD_SAMPLE) && contrib;
      end
      ST_MUL: begin
        mul_en = 1'b1;
      end
      ST_ACC: begin
        acc_en = 1'b1;
      end
      ST_EMIT: begin
        emit = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Gain store; an entry never written reads as unity gain.
  gmsm_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (NUM_CHANNELS)
  ) u_gain_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (idx),
    .wdata (head.gain),
    .re    (rd_en),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign gain_eff = rd_vld_r ? $signed(ram_rdata) : UNITY_GAIN;
  assign prod_nxt = PROD_W'(sample_r) * PROD_W'(gain_eff);

  // Solo count tracks how many channels are soloed.
  assign solo_cnt_nxt = solo_cnt_r + CNT_W'(head.solo) - CNT_W'(solo_r[idx]);

  // Accumulate with saturation at the accumulator limits.
  always_comb begin
    sum = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(prod_r);
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_nxt = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = sum[ACC_W-1:0];
    end
  end

  // Floor shift down to Q1.23 and clamp to the output range.
  always_comb begin
    shifted = acc_r[ACC_W-1:GAIN_FRAC];
    fits    = (&shifted[SH_W-1:MIX_W-1]) || !(|shifted[SH_W-1:MIX_W-1]);
    if (fits) begin
      mix_nxt  = shifted[MIX_W-1:0];
      clip_nxt = 1'b0;
    end else begin
      mix_nxt  = shifted[SH_W-1] ? MIX_MIN : MIX_MAX;
      clip_nxt = 1'b1;
    end
  end

  // Control state, flags and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mute_r      <= '0;
      solo_r      <= '0;
      gvld_r      <= '0;
      solo_cnt_r  <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (set_we) begin
        mute_r[idx] <= head.mute;
        solo_r[idx] <= head.solo;
        gvld_r[idx] <= 1'b1;
        solo_cnt_r  <= solo_cnt_nxt;
      end
      if (acc_en) begin
        acc_r <= acc_nxt;
      end else if (emit) begin
        acc_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sample_r <= head.sample;
      last_r   <= head.last;
    end
    if (rd_en) begin
      rd_vld_r <= gvld_r[idx];
    end
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
    if (emit) begin
      out_mix_r     <= mix_nxt;
      out_clipped_r <= clip_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_mix     = out_mix_r;
  assign out_clipped = out_clipped_r;

  assign status.state    = state_r;
  assign status.emit     = emit;
  assign status.acc_zero = (acc_r == '0);

endmodule

// ===== tb/gain_mute_solo_mixer_test.sv =====
`timescale 1ns / 1ps

module gain_mute_solo_mixer_test;
  import gmsm_pkg::*;

  localparam int NUM_CH       = NUM_CHANNELS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam longint ACC_HI = longint'(ACC_MAX);
  localparam longint ACC_LO = longint'(ACC_MIN);
  localparam longint MIX_HI = longint'(MIX_MAX);
  localparam longint MIX_LO = longint'(MIX_MIN);

  // One input item as it is offered to the mixer.
  typedef struct {
    cmd_t                       cmd;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [GAIN_W-1:0]   gain;
    logic                       mute;
    logic                       solo;
    logic                       last;
  } mixer_item_t;

  // One mixed frame sample with its clip flag.
  typedef struct {
    logic signed [MIX_W-1:0] mix;
    logic                    clipped;
  } frame_mix_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_cmd = 1'b0;
  logic [CHAN_W-1:0]          in_channel = '0;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic signed [GAIN_W-1:0]   in_gain = '0;
  logic                       in_mute = 1'b0;
  logic                       in_solo = 1'b0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [MIX_W-1:0]    out_mix;
  logic                       out_clipped;

  // Items waiting to be offered, and frame sums waiting to come out.
  mixer_item_t send_q[$];
  frame_mix_t  frame_mix_q[$];

  // Shadow of the mixer's channel settings and running frame sum.
  logic signed [GAIN_W-1:0] gain_tab [NUM_CH];
  logic [NUM_CH-1:0]        mute_tab;
  logic [NUM_CH-1:0]        solo_tab;
  longint                   mix_acc;

  // Solo bits in the order they are queued, so generated traffic can release them.
  logic [NUM_CH-1:0] solo_queued = '0;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit in_fire = 1'b0;
  bit hold_request = 1'b0;
  bit hold_served = 1'b0;
  int hold_left = 0;

  gain_mute_solo_mixer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .in_gain     (in_gain),
    .in_mute     (in_mute),
    .in_solo     (in_solo),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_mix     (out_mix),
    .out_clipped (out_clipped)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL gain_mute_solo_mixer");
      $finish;
    end
  end

  // Apply one accepted item to the shadow mixer and queue the frame sum it closes.
  function automatic void advance_mix(input mixer_item_t nxt);
    logic signed [PROD_W-1:0] prod;
    longint                   sum;
    longint                   shifted;
    frame_mix_t               fm;
    if (nxt.cmd == CMD_SETTINGS) begin
      if (nxt.channel < NUM_CH) begin
        gain_tab[nxt.channel] = nxt.gain;
        mute_tab[nxt.channel] = nxt.mute;
        solo_tab[nxt.channel] = nxt.solo;
      end
      return;
    end
    if (nxt.channel < NUM_CH && !mute_tab[nxt.channel] &&
        (solo_tab[nxt.channel] || !(|solo_tab))) begin
      prod = nxt.sample * gain_tab[nxt.channel];
      sum = mix_acc + prod;
      if (sum > ACC_HI) sum = ACC_HI;
      if (sum < ACC_LO) sum = ACC_LO;
      mix_acc = sum;
    end
    if (!nxt.last) return;
    // Floor back to Q1.23, then saturate to the output width.
    shifted = mix_acc >>> GAIN_FRAC;
    fm.clipped = 1'b0;
    if (shifted > MIX_HI) begin
      shifted = MIX_HI;
      fm.clipped = 1'b1;
    end else if (shifted < MIX_LO) begin
      shifted = MIX_LO;
      fm.clipped = 1'b1;
    end
    fm.mix = shifted[MIX_W-1:0];
    frame_mix_q.push_back(fm);
    mix_acc = 0;
  endfunction

  // Monitor: checks results and feeds accepted items to the shadow mixer.
  always @(posedge clk) begin
    frame_mix_t  want;
    mixer_item_t got;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_mix_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected mix item: mix %0d clipped %0b", out_mix, out_clipped);
      end else begin
        want = frame_mix_q.pop_front();
        if (out_mix !== want.mix || out_clipped !== want.clipped) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("mix mismatch: expected %0d clipped %0b, got %0d clipped %0b",
                     want.mix, want.clipped, out_mix, out_clipped);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      got.cmd     = cmd_t'(in_cmd);
      got.channel = in_channel;
      got.sample  = in_sample;
      got.gain    = in_gain;
      got.mute    = in_mute;
      got.solo    = in_solo;
      got.last    = in_last;
      advance_mix(got);
    end
  end

  // Driver: offers the next queued item once the previous one was taken.
  always @(negedge clk) begin
    mixer_item_t nxt;
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = send_q.pop_front();
        in_valid   <= 1'b1;
        in_cmd     <= nxt.cmd;
        in_channel <= nxt.channel;
        in_sample  <= nxt.sample;
        in_gain    <= nxt.gain;
        in_mute    <= nxt.mute;
        in_solo    <= nxt.solo;
        in_last    <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Item builders; fields that the command ignores still carry random bits.
  task automatic push_settings(input logic [CHAN_W-1:0] ch, input logic signed [GAIN_W-1:0] g,
                               input logic m, input logic s, input logic l);
    mixer_item_t nxt;
    nxt.cmd     = CMD_SETTINGS;
    nxt.channel = ch;
    nxt.sample  = SAMPLE_W'($urandom());
    nxt.gain    = g;
    nxt.mute    = m;
    nxt.solo    = s;
    nxt.last    = l;
    solo_queued[ch] = s;
    send_q.push_back(nxt);
  endtask

  task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp,
                             input logic l);
    mixer_item_t nxt;
    nxt.cmd     = CMD_SAMPLE;
    nxt.channel = ch;
    nxt.sample  = smp;
    nxt.gain    = GAIN_W'($urandom());
    nxt.mute    = 1'($urandom_range(0, 1));
    nxt.solo    = 1'($urandom_range(0, 1));
    nxt.last    = l;
    send_q.push_back(nxt);
  endtask

  // Most traffic sits on a few channels so settings and samples meet often.
  function automatic logic [CHAN_W-1:0] pick_channel();
    if ($urandom_range(0, 99) < 80) return CHAN_W'($urandom_range(0, 7));
    return CHAN_W'($urandom_range(0, NUM_CH - 1));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return UNITY_GAIN;
      1: return GAIN_MAX;
      2: return GAIN_MIN;
      3: return '0;
      4, 5: return GAIN_W'($urandom_range(0, 32768));
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // Random traffic: mostly frames with occasional settings, some noise items,
  // releases of stuck solos, and rare loud frames that saturate the sum.
  task automatic queue_random_traffic(input int target);
    int                         start;
    int                         len;
    int                         roll;
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] smp;
    start = send_q.size();
    while (send_q.size() - start < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
        ch = pick_channel();
        push_settings(ch, GAIN_MIN, 1'b0, 1'b1, 1'b0);
        len = $urandom_range(129, 140);
        smp = $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
        for (int k = 0; k < len; k++) push_sample(ch, smp, k == len - 1);
        push_settings(ch, UNITY_GAIN, 1'b0, 1'b0, 1'b0);
      end else if (roll < 11) begin
        if ($urandom_range(0, 1))
          push_settings(pick_channel(), GAIN_W'($urandom()), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        else
          push_sample(pick_channel(), SAMPLE_W'($urandom()), 1'($urandom_range(0, 1)));
      end else if (roll < 16 && |solo_queued) begin
        for (int c = 0; c < NUM_CH; c++) begin
          if (solo_queued[c]) begin
            push_settings(CHAN_W'(c), rand_gain(), 1'b0, 1'b0, 1'b0);
            break;
          end
        end
      end else begin
        if ($urandom_range(0, 99) < 30)
          repeat ($urandom_range(1, 3))
            push_settings(pick_channel(), rand_gain(), $urandom_range(0, 99) < 20,
                          $urandom_range(0, 99) < 8, 1'($urandom_range(0, 1)));
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_sample(pick_channel(), rand_sample(), k == len - 1);
      end
    end
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || in_valid || frame_mix_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_CH; i++) gain_tab[i] = UNITY_GAIN;
    mute_tab = '0;
    solo_tab = '0;
    mix_acc  = 0;
    sender_idle_pct = 26;
    recv_stall_pct  = 77;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames: extremes, rounding, clipping, mute, solo and ignored bits.
    push_sample(5'd0, SAMPLE_MAX, 1'b1);
    push_sample(5'd31, SAMPLE_MIN, 1'b1);
    push_settings(5'd3, GAIN_MAX, 1'b0, 1'b0, 1'b1);
    push_settings(5'd4, GAIN_MIN, 1'b0, 1'b0, 1'b0);
    push_sample(5'd3, SAMPLE_MAX, 1'b0);
    push_sample(5'd4, SAMPLE_MAX, 1'b1);
    push_sample(5'd3, SAMPLE_MAX, 1'b1);
    push_sample(5'd4, SAMPLE_MAX, 1'b1);
    push_settings(5'd5, UNITY_GAIN, 1'b1, 1'b0, 1'b0);
    push_sample(5'd5, 24'sd1000, 1'b1);
    push_settings(5'd6, UNITY_GAIN, 1'b0, 1'b1, 1'b0);
    push_sample(5'd0, 24'sd5000, 1'b0);
    push_sample(5'd6, -24'sd7, 1'b1);
    push_settings(5'd8, UNITY_GAIN, 1'b1, 1'b1, 1'b0);
    push_sample(5'd8, 24'sd100, 1'b1);
    push_settings(5'd8, UNITY_GAIN, 1'b0, 1'b0, 1'b0);
    push_settings(5'd6, UNITY_GAIN, 1'b0, 1'b0, 1'b0);
    push_sample(5'd1, 24'sd12, 1'b0);
    push_sample(5'd1, -24'sd3, 1'b0);
    push_sample(5'd2, 24'sd1, 1'b1);
    push_settings(5'd7, '0, 1'b0, 1'b0, 1'b0);
    push_sample(5'd7, SAMPLE_MAX, 1'b1);
    push_sample(5'd0, -24'sd1, 1'b1);

    queue_random_traffic(520);
    wait_drained();

    sender_idle_pct = 77;
    recv_stall_pct  = 26;
    queue_random_traffic(530);
    wait_drained();

    // Full rate, with one long receiver hold-off so the input side backs up.
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 1'b1;
    queue_random_traffic(530);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && frame_mix_q.size() == 0)
      $display("PASS gain_mute_solo_mixer");
    else
      $display("FAIL gain_mute_solo_mixer");
    $finish;
  end

endmodule
